// ===== rtl/box_mean_smoothing_filter_assert.svh =====
// Assertion macros for the box mean smoothing filter.
`ifndef BOX_MEAN_SMOOTHING_FILTER_ASSERT_SVH
`define BOX_MEAN_SMOOTHING_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define BMSF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("box filter check failed");
// Checks that a condition never holds outside reset.
`define BMSF_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("box filter forbidden condition");
`else
`define BMSF_ASSERT(lbl, prop)
`define BMSF_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/bmsf_pkg.sv =====
// Package with sizes, codes and types for the box mean smoothing filter.
`timescale 1ns / 1ps
package bmsf_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int POS_W      = $clog2(MAX_WIDTH + 1);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int CFG_W      = 11;
    localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int ITEM_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                       + MAX_RADIUS + 1);
    localparam int WIN_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W      = $clog2(WIN_MAX + 1);
    localparam int SUM_W      = $clog2(WIN_MAX * 255 + 1);
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int ADDR_W     = RING_W + COL_W;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    // Window modes.
    localparam logic [1:0] MODE_ROW    = 2'd0;
    localparam logic [1:0] MODE_COL    = 2'd1;
    localparam logic [1:0] MODE_SQUARE = 2'd2;
    localparam logic [1:0] MODE_ALT_SQ = 2'd3;

    // Control from the sequencer to every channel lane.
    typedef struct packed {
        logic clear;
        logic acc;
        logic start;
    } t_lane_ctl;
endpackage

// ===== rtl/bmsf_if.sv =====
// Handshake interfaces for the pixel input and the smoothed pixel output.
`timescale 1ns / 1ps
interface bmsf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       drain;
    modport source (output valid, red_in, green_in, blue_in, drain, input ready);
    modport sink (input valid, red_in, green_in, blue_in, drain, output ready);
endinterface

interface bmsf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ===== rtl/box_mean_smoothing_filter.sv =====
// Top level of the box mean smoothing filter: sequencer, line store and lanes.
//
//  channel   dir  handshake            beat contents
//  i_pix     in   valid / ready        red_in, green_in, blue_in, drain
//  o_res     out  valid / ready        red_out, green_out, blue_out, frame_last
//  i_cfg_*   in   write enable only    register index, data
//
// An item with no result passes S_IN and S_PROC only; an item with a result also
// scans its n in-image window pixels (up to 225) in S_SUM, then passes S_FLUSH,
// S_START, S_DIV and S_OUT. The single read port of the line store delivers one
// window pixel per cycle and the lane dividers retire one quotient bit per cycle.
// The first pixel of a frame makes an extra pass through S_PROC to latch the frame settings.
// Reset is synchronous and clears the sequencer and frame state; the line store is
// not cleared. A stalled output holds its beat while the next item is taken in;
// an item with a result waits at the end until that beat has left.
`timescale 1ns / 1ps
`include "box_mean_smoothing_filter_assert.svh"
module box_mean_smoothing_filter
    import bmsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bmsf_pix_if.sink         i_pix,
    bmsf_res_if.source       o_res
);
    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_PROC  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_cfg_w, r_cfg_h;
    logic [2:0]        r_cfg_r;
    logic [1:0]        r_cfg_mode;
    logic [POS_W-1:0]  r_w, r_h;
    logic [RAD_W-1:0]  r_r;
    logic [1:0]        r_mode;
    logic [LAG_W-1:0]  r_lag;
    logic              r_active;
    logic              r_drain;
    logic [23:0]       r_pix;
    logic [POS_W-1:0]  r_in_col, r_in_row, r_out_col, r_out_row;
    logic [ITEM_W-1:0] r_items;
    logic [POS_W-1:0]  r_yhi, r_xlo, r_xhi, r_y, r_x;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_acc_en;
    logic [23:0]       r_q;
    logic [23:0]       r_store [RING_ROWS * MAX_WIDTH];
    logic              r_out_v;
    logic [23:0]       r_out_rgb;
    logic              r_out_last;

    logic [POS_W-1:0]  w_cw, w_ch;
    logic [RAD_W-1:0]  w_cr;
    logic [1:0]        w_cmode;
    logic [LAG_W-1:0]  w_rw;
    logic [RAD_W-1:0]  w_ry, w_rx;
    logic [POS_W:0]    w_yhi_t, w_xhi_t;
    logic [POS_W-1:0]  w_ylo, w_yhi, w_xlo, w_xhi;
    logic              w_pix_in, w_skip, w_we, w_load, w_last;
    logic [ITEM_W-1:0] w_items_nx;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    t_lane_ctl         w_ctl;
    logic [7:0]        w_mean [3];
    logic [2:0]        w_busy;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= CFG_W'(1024);
            r_cfg_h    <= CFG_W'(1024);
            r_cfg_r    <= 3'd1;
            r_cfg_mode <= MODE_SQUARE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_cfg_w    <= i_cfg_data;
                REG_HEIGHT: r_cfg_h    <= i_cfg_data;
                REG_RADIUS: r_cfg_r    <= i_cfg_data[2:0];
                REG_MODE:   r_cfg_mode <= i_cfg_data[1:0];
                default:    r_cfg_r    <= r_cfg_r;
            endcase
        end
    end

    // Frame settings as latched at the first pixel, with range limits.
    always_comb begin
        w_cw = (r_cfg_w == '0) ? POS_W'(1)
             : (r_cfg_w > CFG_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : POS_W'(r_cfg_w);
        w_ch = (r_cfg_h == '0) ? POS_W'(1)
             : (r_cfg_h > CFG_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) : POS_W'(r_cfg_h);
        w_cr = (r_cfg_r > 3'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_cfg_r);
        w_cmode = (r_cfg_mode == MODE_ALT_SQ) ? MODE_SQUARE : r_cfg_mode;
        w_rw = LAG_W'(w_cr) * LAG_W'(w_cw);
    end

    // Window bounds around the next output position, clipped to the image.
    always_comb begin
        w_ry = (r_mode != MODE_ROW) ? r_r : '0;
        w_rx = (r_mode != MODE_COL) ? r_r : '0;
        w_ylo = (r_out_row < POS_W'(w_ry)) ? '0 : r_out_row - POS_W'(w_ry);
        w_xlo = (r_out_col < POS_W'(w_rx)) ? '0 : r_out_col - POS_W'(w_rx);
        w_yhi_t = {1'b0, r_out_row} + (POS_W + 1)'(w_ry);
        w_xhi_t = {1'b0, r_out_col} + (POS_W + 1)'(w_rx);
        w_yhi = (w_yhi_t > {1'b0, r_h - 1'b1}) ? r_h - 1'b1 : w_yhi_t[POS_W-1:0];
        w_xhi = (w_xhi_t > {1'b0, r_w - 1'b1}) ? r_w - 1'b1 : w_xhi_t[POS_W-1:0];
    end

    assign w_pix_in   = r_in_row < r_h;
    assign w_skip     = w_pix_in && r_drain;
    assign w_we       = (r_state == S_PROC) && r_active && w_pix_in && !r_drain;
    assign w_items_nx = r_items + 1'b1;
    assign w_load     = (r_state == S_OUT) && (!r_out_v || o_res.ready);
    assign w_last     = (r_out_row == r_h - 1'b1) && (r_out_col == r_w - 1'b1);
    assign w_waddr    = {r_in_row[RING_W-1:0], r_in_col[COL_W-1:0]};
    assign w_raddr    = {r_y[RING_W-1:0], r_x[COL_W-1:0]};

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IN: begin
                if (i_pix.valid) n_state = S_PROC;
            end
            S_PROC: begin
                if (!r_active) begin
                    if (r_drain) n_state = S_IN;
                end else if (w_skip || (w_items_nx <= ITEM_W'(r_lag))) begin
                    n_state = S_IN;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_x == r_xhi && r_y == r_yhi) n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (!w_busy[0]) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) n_state = S_IN;
            end
            default: n_state = S_IN;
        endcase
    end

    // Control state: sequencer, frame positions and item count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_active  <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_items   <= '0;
            r_acc_en  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc_en <= (r_state == S_SUM);
            if (r_state == S_PROC) begin
                if (!r_active) begin
                    r_active <= !r_drain;
                end else if (!w_skip) begin
                    r_items <= w_items_nx;
                    if (w_pix_in) begin
                        if (r_in_col + 1'b1 >= r_w) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 1'b1;
                        end else begin
                            r_in_col <= r_in_col + 1'b1;
                        end
                    end
                end
            end
            if (w_load) begin
                if (w_last) begin
                    r_active  <= 1'b0;
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_items   <= '0;
                end else if (r_out_col + 1'b1 >= r_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // Item capture, frame latch and window scan.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IN && i_pix.valid) begin
            r_pix   <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_drain <= i_pix.drain;
        end
        if (r_state == S_PROC && !r_active) begin
            r_w    <= w_cw;
            r_h    <= w_ch;
            r_r    <= w_cr;
            r_mode <= w_cmode;
            unique case (w_cmode)
                MODE_ROW: r_lag <= LAG_W'(w_cr);
                MODE_COL: r_lag <= w_rw;
                default:  r_lag <= w_rw + LAG_W'(w_cr);
            endcase
        end
        if (r_state == S_PROC) begin
            r_yhi <= w_yhi;
            r_xlo <= w_xlo;
            r_xhi <= w_xhi;
            r_y   <= w_ylo;
            r_x   <= w_xlo;
            r_cnt <= '0;
        end else begin
            if (r_state == S_SUM) begin
                if (r_x == r_xhi) begin
                    r_x <= r_xlo;
                    r_y <= r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (r_acc_en) r_cnt <= r_cnt + 1'b1;
        end
    end

    // Line store ring: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) r_store[w_waddr] <= r_pix;
        r_q <= r_store[w_raddr];
    end

    // Channel lanes.
    assign w_ctl.clear = (r_state == S_PROC);
    assign w_ctl.acc   = r_acc_en;
    assign w_ctl.start = (r_state == S_START);

    for (genvar g = 0; g < 3; g++) begin : g_lane
        bmsf_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pixel (r_q[23 - 8 * g -: 8]),
            .i_count (r_cnt),
            .o_mean  (w_mean[g]),
            .o_busy  (w_busy[g])
        );
    end

    // Merge the lane results into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
        if (w_load) begin
            r_out_rgb  <= {w_mean[0], w_mean[1], w_mean[2]};
            r_out_last <= w_last;
        end
    end

    assign i_pix.ready      = (r_state == S_IN);
    assign o_res.valid      = r_out_v;
    assign o_res.red_out    = r_out_rgb[23:16];
    assign o_res.green_out  = r_out_rgb[15:8];
    assign o_res.blue_out   = r_out_rgb[7:0];
    assign o_res.frame_last = r_out_last;

    // Checks on the sequencer and lanes.
    `BMSF_ASSERT(a_div_count, (r_state == S_START) |-> (r_cnt != '0))
    `BMSF_ASSERT(a_lanes_lockstep, (w_busy[0] == w_busy[1]) && (w_busy[1] == w_busy[2]))
    `BMSF_ASSERT(a_last_ends_frame, (w_load && w_last) |=> !r_active)
    `BMSF_NEVER(a_write_idle, w_we && !r_active)
endmodule

// ===== rtl/bmsf_lane.sv =====
// One color channel lane: window sum accumulator and restoring divider.
`timescale 1ns / 1ps
module bmsf_lane
    import bmsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  logic [7:0]       i_pixel,
    input  logic [CNT_W-1:0] i_count,
    output logic [7:0]       o_mean,
    output logic             o_busy
);
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_quo;
    logic [SUM_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [SUM_W:0]    w_trial;
    logic              w_fits;

    // One quotient bit per cycle: shift in the next dividend bit and try the count.
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fits  = w_trial >= (SUM_W + 1)'(i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == STEP_W'(SUM_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    // Accumulate the window, then divide it by the pixel count.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + SUM_W'(i_pixel);
        end
        if (i_ctl.start) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_quo  <= {r_quo[SUM_W-2:0], w_fits};
            r_rem  <= w_fits ? SUM_W'(w_trial - (SUM_W + 1)'(i_count)) : w_trial[SUM_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    assign o_mean = r_quo[7:0];
    assign o_busy = r_busy;
endmodule
